// ----- rtl/rft_pkg.sv -----
// Shared types and constants for the rigid frame transform core.
`timescale 1ns / 1ps
package rft_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int ROT_FRAC_BITS = 14;
	localparam int ENTRY_W       = 16;
	localparam int ROW_W         = 3 * ENTRY_W;
	localparam int IDX_W         = 3;
	localparam int V_W           = COORD_WIDTH + 1;
	localparam int PROD_W        = V_W + ENTRY_W;
	localparam int SUM_W         = PROD_W + 2;

	localparam logic [ENTRY_W-1:0] ROT_ONE = ENTRY_W'(16384);

	localparam logic [1:0] CMD_VEC_TO_LOCAL = 2'd0;
	localparam logic [1:0] CMD_VEC_TO_WORLD = 2'd1;
	localparam logic [1:0] CMD_PT_TO_LOCAL  = 2'd2;
	localparam logic [1:0] CMD_PT_TO_WORLD  = 2'd3;

	localparam logic [IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd3;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd4;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Z = 3'd5;

	typedef struct packed {
		logic [1:0]                    cmd;
		logic signed [COORD_WIDTH-1:0] in_x;
		logic signed [COORD_WIDTH-1:0] in_y;
		logic signed [COORD_WIDTH-1:0] in_z;
		logic                          in_last;
	} in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] out_x;
		logic signed [COORD_WIDTH-1:0] out_y;
		logic signed [COORD_WIDTH-1:0] out_z;
		logic                          out_last;
		logic                          saturated;
	} out_t;

	typedef struct packed {
		logic [2:0][ROW_W-1:0]       rot_row;
		logic [2:0][COORD_WIDTH-1:0] origin;
	} cfg_t;

	// products [output axis][input axis]
	typedef struct packed {
		logic [2:0][2:0][PROD_W-1:0] prod;
		logic                        add_org;
		logic                        last;
	} prod_t;

endpackage

// ----- rtl/rft_cfg.sv -----
// Configuration registers: rotation rows and frame origin.
`timescale 1ns / 1ps
module rft_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rft_pkg::IDX_W-1:0] cfg_index,
	input  logic [rft_pkg::ROW_W-1:0] cfg_wdata,
	output rft_pkg::cfg_t             cfg
);
	import rft_pkg::*;

	logic [2:0][ROW_W-1:0]       rot_row_q;
	logic [2:0][COORD_WIDTH-1:0] origin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_row_q[0] <= ROW_W'(ROT_ONE);
			rot_row_q[1] <= ROW_W'(ROT_ONE) << ENTRY_W;
			rot_row_q[2] <= ROW_W'(ROT_ONE) << (2 * ENTRY_W);
			origin_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROT_ROW0: rot_row_q[0] <= cfg_wdata;
				REG_ROT_ROW1: rot_row_q[1] <= cfg_wdata;
				REG_ROT_ROW2: rot_row_q[2] <= cfg_wdata;
				REG_ORIGIN_X: origin_q[0]  <= cfg_wdata[COORD_WIDTH-1:0];
				REG_ORIGIN_Y: origin_q[1]  <= cfg_wdata[COORD_WIDTH-1:0];
				REG_ORIGIN_Z: origin_q[2]  <= cfg_wdata[COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.rot_row = rot_row_q;
	assign cfg.origin  = origin_q;

endmodule

// ----- rtl/rft_front.sv -----
// Front pipeline: operand select and origin subtract (s1), nine products (s2).
`timescale 1ns / 1ps
module rft_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rft_pkg::in_t   in_data,
	input  rft_pkg::cfg_t  cfg,
	output logic           out_valid,
	input  logic           out_ready,
	output rft_pkg::prod_t out_data
);
	import rft_pkg::*;

	logic                            valid_s1;
	logic [2:0][V_W-1:0]             v_s1;
	logic [2:0][2:0][ENTRY_W-1:0]    coef_s1;
	logic                            add_org_s1;
	logic                            last_s1;

	logic                            valid_s2;
	logic [2:0][2:0][PROD_W-1:0]     prod_s2;
	logic                            add_org_s2;
	logic                            last_s2;

	logic                            ready_s1;
	logic                            ready_s2;
	logic                            to_world;
	logic                            sub_org;
	logic [2:0][COORD_WIDTH-1:0]     in_c;
	logic [2:0][V_W-1:0]             v_d;
	logic [2:0][2:0][ENTRY_W-1:0]    coef_d;
	logic [2:0][2:0][PROD_W-1:0]     prod_d;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	assign to_world = (in_data.cmd == CMD_VEC_TO_WORLD) || (in_data.cmd == CMD_PT_TO_WORLD);
	assign sub_org  = (in_data.cmd == CMD_PT_TO_LOCAL);
	assign in_c     = {in_data.in_z, in_data.in_y, in_data.in_x};

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			v_d[j] = V_W'($signed(in_c[j]))
				- (sub_org ? V_W'($signed(cfg.origin[j])) : V_W'(0));
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				coef_d[i][j] = to_world ? cfg.rot_row[i][ENTRY_W*j +: ENTRY_W]
					: cfg.rot_row[j][ENTRY_W*i +: ENTRY_W];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_d[i][j] = PROD_W'($signed(v_s1[j]) * $signed(coef_s1[i][j]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			v_s1       <= v_d;
			coef_s1    <= coef_d;
			add_org_s1 <= (in_data.cmd == CMD_PT_TO_WORLD);
			last_s1    <= in_data.in_last;
		end
		if (ready_s2 && valid_s1) begin
			prod_s2    <= prod_d;
			add_org_s2 <= add_org_s1;
			last_s2    <= last_s1;
		end
	end

	assign out_valid        = valid_s2;
	assign out_data.prod    = prod_s2;
	assign out_data.add_org = add_org_s2;
	assign out_data.last    = last_s2;

`ifndef SYNTHESIS
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(prod_s2))
		else $error("s2 transaction lost or changed under stall");
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 |=> valid_s2)
		else $error("s1 transaction not moved into s2");
`endif

endmodule

// ----- rtl/rft_back.sv -----
// Back pipeline: dot sums (s3), floor shift and origin add (s4), saturation (s5).
`timescale 1ns / 1ps
module rft_back #(
	parameter int ROT_FRAC_BITS = rft_pkg::ROT_FRAC_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rft_pkg::prod_t in_data,
	input  rft_pkg::cfg_t  cfg,
	output logic           out_valid,
	input  logic           out_ready,
	output rft_pkg::out_t  out_data
);
	import rft_pkg::*;

	localparam int RES_W = SUM_W + 1;
	localparam logic [RES_W-1:0] SAT_HI =
		{{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [RES_W-1:0] SAT_LO = ~SAT_HI;

	logic                        valid_s3;
	logic [2:0][SUM_W-1:0]       sum_s3;
	logic                        add_org_s3;
	logic                        last_s3;

	logic                        valid_s4;
	logic [2:0][RES_W-1:0]       res_s4;
	logic                        last_s4;

	logic                        valid_s5;
	logic [2:0][COORD_WIDTH-1:0] coord_s5;
	logic                        last_s5;
	logic                        sat_s5;

	logic                        ready_s3;
	logic                        ready_s4;
	logic                        ready_s5;
	logic [2:0][SUM_W-1:0]       sum_d;
	logic [2:0][SUM_W-1:0]       shr_d;
	logic [2:0][RES_W-1:0]       res_d;
	logic [2:0][COORD_WIDTH-1:0] coord_d;
	logic [2:0]                  clip_d;

	assign ready_s5 = !valid_s5 || out_ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_d[i] = SUM_W'($signed(in_data.prod[i][0]))
				+ SUM_W'($signed(in_data.prod[i][1]))
				+ SUM_W'($signed(in_data.prod[i][2]));
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shr_d[i] = SUM_W'($signed(sum_s3[i]) >>> ROT_FRAC_BITS);
			res_d[i] = RES_W'($signed(shr_d[i]))
				+ (add_org_s3 ? RES_W'($signed(cfg.origin[i])) : RES_W'(0));
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if ($signed(res_s4[i]) > $signed(SAT_HI)) begin
				coord_d[i] = SAT_HI[COORD_WIDTH-1:0];
				clip_d[i]  = 1'b1;
			end else if ($signed(res_s4[i]) < $signed(SAT_LO)) begin
				coord_d[i] = SAT_LO[COORD_WIDTH-1:0];
				clip_d[i]  = 1'b1;
			end else begin
				coord_d[i] = res_s4[i][COORD_WIDTH-1:0];
				clip_d[i]  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s3) valid_s3 <= in_valid;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			sum_s3     <= sum_d;
			add_org_s3 <= in_data.add_org;
			last_s3    <= in_data.last;
		end
		if (ready_s4 && valid_s3) begin
			res_s4  <= res_d;
			last_s4 <= last_s3;
		end
		if (ready_s5 && valid_s4) begin
			coord_s5 <= coord_d;
			last_s5  <= last_s4;
			sat_s5   <= |clip_d;
		end
	end

	assign out_valid          = valid_s5;
	assign out_data.out_x     = coord_s5[0];
	assign out_data.out_y     = coord_s5[1];
	assign out_data.out_z     = coord_s5[2];
	assign out_data.out_last  = last_s5;
	assign out_data.saturated = sat_s5;

`ifndef SYNTHESIS
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && sat_s5 |->
			coord_s5[0] == SAT_HI[COORD_WIDTH-1:0] || coord_s5[0] == SAT_LO[COORD_WIDTH-1:0] ||
			coord_s5[1] == SAT_HI[COORD_WIDTH-1:0] || coord_s5[1] == SAT_LO[COORD_WIDTH-1:0] ||
			coord_s5[2] == SAT_HI[COORD_WIDTH-1:0] || coord_s5[2] == SAT_LO[COORD_WIDTH-1:0])
		else $error("saturation flag without a clipped coordinate");
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !ready_s5 |=> valid_s4 && $stable(res_s4))
		else $error("s4 transaction lost or changed under stall");
`endif

endmodule

// ----- rtl/rigid_frame_transform_core.sv -----
// Top level of the rigid frame transform core.
`timescale 1ns / 1ps
// Rotates 3D Q16.16 vectors and points between world and local frames using a
// Q2.14 3x3 rotation and an origin held in the configuration registers. The
// core is a five-stage pipeline (operand select, multiply, sum, shift and origin
// add, saturate) built on nine parallel 33x16 multipliers, and takes one
// transaction per clock while the result side does not stall. Backpressure
// on the result side stalls the pipeline without losing or repeating a
// transaction. Configuration should only be written while no transaction is
// in flight.
module rigid_frame_transform_core #(
	parameter int ROT_FRAC_BITS = rft_pkg::ROT_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pt_valid,
	output logic                      pt_stall,
	input  rft_pkg::in_t              pt,
	output logic                      res_valid,
	input  logic                      res_stall,
	output rft_pkg::out_t             res,
	input  logic                      cfg_we,
	input  logic [rft_pkg::IDX_W-1:0] cfg_index,
	input  logic [rft_pkg::ROW_W-1:0] cfg_wdata
);
	import rft_pkg::*;

	cfg_t  cfg;
	prod_t prod;
	logic  front_ready;
	logic  prod_valid;
	logic  back_ready;

	rft_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rft_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pt_valid),
		.in_ready  (front_ready),
		.in_data   (pt),
		.cfg       (cfg),
		.out_valid (prod_valid),
		.out_ready (back_ready),
		.out_data  (prod)
	);

	rft_back #(
		.ROT_FRAC_BITS (ROT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.in_ready  (back_ready),
		.in_data   (prod),
		.cfg       (cfg),
		.out_valid (res_valid),
		.out_ready (!res_stall),
		.out_data  (res)
	);

	assign pt_stall = !front_ready;

endmodule
